FILE: sv/shdr_pkg.sv
// Package for the signal history de-duplication ring.
// Holds the stored entry type, command and status codes, and the FSM state type.
// Depends on nothing; shdr_cell, shdr_head, the top level and the testbench use it.
`default_nettype none

package shdr_pkg;

  localparam int unsigned PARAM_BYTES = 4;
  localparam logic [31:0] PARAM_MASK  = (PARAM_BYTES >= 4) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << (8 * PARAM_BYTES)) - 64'd1);
  localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] code;
    logic [7:0]  bit_length;
    logic [15:0] pulse_length;
    logic [31:0] params;
    logic        inverted;
    logic [15:0] repeat_count;
    logic [47:0] time_ms;
  } entry_t;

  typedef enum logic {
    CMD_UPSERT = 1'b0,
    CMD_SHIFT  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_DUP      = 2'd0,
    STATUS_UPDATED  = 2'd1,
    STATUS_INSERTED = 2'd2,
    STATUS_SHIFTED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_COMMIT = 2'd2
  } fsm_e;

  typedef struct packed {
    logic rotate;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic match;
    logic dup;
  } head_res_t;

endpackage

`default_nettype wire

FILE: sv/shdr_in_if.sv
// Input channel of the signal history ring: valid/ready handshake and item payload.
// Depends on nothing.
`default_nettype none

interface shdr_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [31:0]        signal_code;
  logic [7:0]         bit_length;
  logic [15:0]        pulse_length;
  logic [31:0]        protocol_params;
  logic               inverted;
  logic [15:0]        repeat_count;
  logic [47:0]        time_ms;
  logic signed [47:0] delta_ms;

  modport source (
    output valid, cmd, signal_code, bit_length, pulse_length, protocol_params,
           inverted, repeat_count, time_ms, delta_ms,
    input  ready
  );

  modport sink (
    input  valid, cmd, signal_code, bit_length, pulse_length, protocol_params,
           inverted, repeat_count, time_ms, delta_ms,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/shdr_out_if.sv
// Result channel of the signal history ring: valid/ready handshake and result payload.
// Depends on nothing.
`default_nettype none

interface shdr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot;
  logic [4:0] entry_count;

  modport source (
    output valid, status, slot, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, slot, entry_count,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/shdr_cell.sv
// One storage cell of the ring: holds a single history entry.
// Rotates in from its neighbor or loads a new item; uses shdr_pkg.
`default_nettype none

module shdr_cell (
  input  wire logic                clk_i,
  input  wire shdr_pkg::cell_ctrl_t ctrl_i,
  input  wire shdr_pkg::entry_t    ring_i,
  input  wire shdr_pkg::entry_t    item_i,
  output shdr_pkg::entry_t         entry_o
);

  shdr_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= item_i;
    end else if (ctrl_i.rotate) begin
      entry_q <= ring_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: sv/shdr_head.sv
// Head unit of the ring: matches, refreshes, rewrites or time-shifts the entry
// that currently sits in the first cell. Uses shdr_pkg.
`default_nettype none

module shdr_head (
  input  wire shdr_pkg::cmd_e    cmd_i,
  input  wire logic              live_i,
  input  wire shdr_pkg::entry_t  query_i,
  input  wire logic signed [47:0] delta_i,
  input  wire logic [31:0]       window_i,
  input  wire shdr_pkg::entry_t  entry_i,
  output shdr_pkg::entry_t       entry_o,
  output shdr_pkg::head_res_t    res_o
);

  logic [49:0] sum;
  logic [48:0] diff;

  always_comb begin
    sum     = {2'b00, entry_i.time_ms} + {{2{delta_i[47]}}, delta_i};
    diff    = {1'b0, query_i.time_ms} - {1'b0, entry_i.time_ms};
    entry_o = entry_i;
    res_o   = '0;
    if (live_i) begin
      unique case (cmd_i)
        shdr_pkg::CMD_SHIFT: begin
          if (sum[49]) begin
            entry_o.time_ms = '0;
          end else if (sum[48]) begin
            entry_o.time_ms = shdr_pkg::TIME_MAX;
          end else begin
            entry_o.time_ms = sum[47:0];
          end
        end
        shdr_pkg::CMD_UPSERT: begin
          if (entry_i.code == query_i.code) begin
            res_o.match = 1'b1;
            res_o.dup   = !diff[48] && (diff[47:0] <= {16'b0, window_i});
            if (res_o.dup) begin
              entry_o.time_ms = query_i.time_ms;
            end else begin
              entry_o = query_i;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/signal_history_dedup_ring.sv
// Signal history ring with de-duplication of repeated codes inside a time window.
// Top level; uses shdr_pkg, shdr_in_if, shdr_out_if, shdr_cell and shdr_head.
//
// The block keeps HISTORY_DEPTH received codes in a ring of cells that rotate by
// one position per cycle during a scan past a single head unit. Each item, upsert or shift,
// takes one full revolution of the ring followed by a commit step; the commit
// waits while the last result is still untaken, and no new item is accepted
// until it is done. An insertion of a new code is written into its slot in the
// commit cycle together with the result.
`default_nettype none

module signal_history_dedup_ring #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  shdr_in_if.sink          in_i,
  shdr_out_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);

  shdr_pkg::fsm_e    state_q, state_d;
  logic [IDX_W-1:0]  step_q;
  logic [IDX_W-1:0]  slot_q;
  logic [IDX_W-1:0]  wp_q, wp_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              found_q;
  logic              dup_q;
  logic [31:0]       window_q;
  shdr_pkg::cmd_e    cmd_q;
  shdr_pkg::entry_t  query_q;
  logic signed [47:0] delta_q;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [3:0]        out_slot_q;
  logic [4:0]        out_count_q;

  logic              accept;
  logic              scanning;
  logic              commit;
  logic              insert;
  logic              live;
  shdr_pkg::entry_t  head_in;
  shdr_pkg::entry_t  head_out;
  shdr_pkg::head_res_t head_res;
  shdr_pkg::status_e status_sel;
  logic [IDX_W-1:0]  slot_sel;
  logic [IDX_W+3:0]  slot_pad;
  logic [CNT_W+4:0]  count_pad;
  shdr_pkg::entry_t  item;

  shdr_pkg::entry_t  cell_out [HISTORY_DEPTH];

  assign accept   = in_i.valid && in_i.ready;
  assign scanning = (state_q == shdr_pkg::S_SCAN);
  assign commit   = (state_q == shdr_pkg::S_COMMIT) && (!out_valid_q || out_o.ready);
  assign insert   = commit && (cmd_q == shdr_pkg::CMD_UPSERT) && !found_q;
  assign live     = scanning && (CNT_W'(step_q) < count_q) &&
                    !((cmd_q == shdr_pkg::CMD_UPSERT) && found_q);

  assign in_i.ready = (state_q == shdr_pkg::S_IDLE);

  assign item.code         = in_i.signal_code;
  assign item.bit_length   = in_i.bit_length;
  assign item.pulse_length = in_i.pulse_length;
  assign item.params       = in_i.protocol_params & shdr_pkg::PARAM_MASK;
  assign item.inverted     = in_i.inverted;
  assign item.repeat_count = in_i.repeat_count;
  assign item.time_ms      = in_i.time_ms;

  assign head_in = cell_out[0];

  shdr_head u_head (
    .cmd_i   (cmd_q),
    .live_i  (live),
    .query_i (query_q),
    .delta_i (delta_q),
    .window_i(window_q),
    .entry_i (head_in),
    .entry_o (head_out),
    .res_o   (head_res)
  );

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    shdr_pkg::cell_ctrl_t ctrl;
    shdr_pkg::entry_t     ring_in;

    assign ctrl.rotate = scanning;
    assign ctrl.load   = insert && (wp_q == IDX_W'(i));

    if (i == HISTORY_DEPTH - 1) begin : g_tail
      assign ring_in = head_out;
    end else begin : g_mid
      assign ring_in = cell_out[i+1];
    end

    shdr_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .ring_i (ring_in),
      .item_i (query_q),
      .entry_o(cell_out[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shdr_pkg::S_IDLE: begin
        if (accept) begin
          state_d = shdr_pkg::S_SCAN;
        end
      end
      shdr_pkg::S_SCAN: begin
        if (step_q == LAST_IDX) begin
          state_d = shdr_pkg::S_COMMIT;
        end
      end
      shdr_pkg::S_COMMIT: begin
        if (commit) begin
          state_d = shdr_pkg::S_IDLE;
        end
      end
      default: state_d = shdr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_q == shdr_pkg::CMD_SHIFT) begin
      status_sel = shdr_pkg::STATUS_SHIFTED;
      slot_sel   = '0;
    end else if (found_q) begin
      status_sel = dup_q ? shdr_pkg::STATUS_DUP : shdr_pkg::STATUS_UPDATED;
      slot_sel   = slot_q;
    end else begin
      status_sel = shdr_pkg::STATUS_INSERTED;
      slot_sel   = wp_q;
    end
    wp_d    = wp_q;
    count_d = count_q;
    if (insert) begin
      wp_d = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
      if (count_q < FULL_CNT) begin
        count_d = count_q + 1'b1;
      end
    end
    slot_pad  = {4'b0, slot_sel};
    count_pad = {5'b0, count_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shdr_pkg::S_IDLE;
      step_q      <= '0;
      wp_q        <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (accept) begin
        step_q  <= '0;
        found_q <= 1'b0;
      end else if (scanning) begin
        step_q <= (step_q == LAST_IDX) ? '0 : step_q + 1'b1;
        if (head_res.match) begin
          found_q <= 1'b1;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= shdr_pkg::cmd_e'(in_i.cmd);
      query_q <= item;
      delta_q <= in_i.delta_ms;
    end
    if (scanning && head_res.match) begin
      dup_q  <= head_res.dup;
      slot_q <= step_q;
    end
    if (commit) begin
      out_status_q <= status_sel;
      out_slot_q   <= slot_pad[3:0];
      out_count_q  <= count_pad[4:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.slot        = out_slot_q;
  assign out_o.entry_count = out_count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count exceeds the ring depth");

  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < FULL_CNT) |-> (CNT_W'(wp_q) == count_q))
    else $error("write pointer out of step with the fill count");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == shdr_pkg::S_COMMIT))
    else $error("result raised outside the commit cycle");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != shdr_pkg::S_SCAN) |-> (step_q == '0))
    else $error("scan step counter not at rest outside a scan");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for signal_history_dedup_ring: directed and random upsert and shift items.
// A scoreboard class predicts status, slot and entry count for every accepted item.
// Depends on shdr_pkg, shdr_in_if, shdr_out_if and the signal_history_dedup_ring RTL.

module tb_top;

  localparam int DEPTH = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam longint TIMEOUT = 64'd400_000 * 64'd20;

  typedef struct {
    shdr_pkg::cmd_e cmd;
    logic [31:0]    signal_code;
    logic [7:0]     bit_length;
    logic [15:0]    pulse_length;
    logic [31:0]    protocol_params;
    logic           inverted;
    logic [15:0]    repeat_count;
    logic [47:0]    time_ms;
    logic [47:0]    delta_ms;
  } ring_item_t;

  typedef struct {
    shdr_pkg::status_e status;
    logic [3:0]        slot;
    logic [4:0]        entry_count;
  } outcome_t;

  class dedup_history;
    logic [31:0] code_at[DEPTH];
    logic [47:0] stamp_at[DEPTH];
    int unsigned next_slot;
    int unsigned filled;
    logic [31:0] window_ms;
    outcome_t    pending[$];
    int          errors;

    function new();
      next_slot = 0;
      filled = 0;
      window_ms = '0;
      errors = 0;
    endfunction

    function void note_item(ring_item_t it);
      outcome_t    o;
      int unsigned pos;
      bit          hit;
      logic [47:0] mag;
      logic [48:0] sum;
      hit = 1'b0;
      o.slot = '0;
      if (it.cmd == shdr_pkg::CMD_SHIFT) begin
        mag = it.delta_ms[47] ? (~it.delta_ms + 48'd1) : it.delta_ms;
        for (int i = 0; i < filled; i++) begin
          if (it.delta_ms[47]) begin
            stamp_at[i] = (mag > stamp_at[i]) ? 48'd0 : stamp_at[i] - mag;
          end else begin
            sum = {1'b0, stamp_at[i]} + {1'b0, mag};
            stamp_at[i] = sum[48] ? shdr_pkg::TIME_MAX : sum[47:0];
          end
        end
        o.status = shdr_pkg::STATUS_SHIFTED;
      end else begin
        o.status = shdr_pkg::STATUS_INSERTED;
        for (int i = 0; i < filled && !hit; i++) begin
          pos = (filled < DEPTH) ? i : (next_slot + i) % DEPTH;
          if (code_at[pos] == it.signal_code) begin
            hit = 1'b1;
            o.slot = 4'(pos);
            if (it.time_ms >= stamp_at[pos] &&
                it.time_ms - stamp_at[pos] <= {16'd0, window_ms}) begin
              o.status = shdr_pkg::STATUS_DUP;
            end else begin
              o.status = shdr_pkg::STATUS_UPDATED;
            end
            stamp_at[pos] = it.time_ms;
          end
        end
        if (!hit) begin
          code_at[next_slot] = it.signal_code;
          stamp_at[next_slot] = it.time_ms;
          o.slot = 4'(next_slot);
          next_slot = (next_slot + 1) % DEPTH;
          if (filled < DEPTH) filled++;
        end
      end
      o.entry_count = 5'(filled);
      pending.push_back(o);
    endfunction

    function void check_outcome(logic [1:0] status, logic [3:0] slot, logic [4:0] count);
      outcome_t exp_o;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: status %0d slot %0d count %0d",
                 $time, status, slot, count);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (status !== exp_o.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, exp_o.status, status);
        errors++;
      end
      if (slot !== exp_o.slot) begin
        $display("%0t: slot mismatch, expected %0d actual %0d", $time, exp_o.slot, slot);
        errors++;
      end
      if (count !== exp_o.entry_count) begin
        $display("%0t: entry_count mismatch, expected %0d actual %0d",
                 $time, exp_o.entry_count, count);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  bit          steady;
  bit          flood_phase;
  bit          flood_done;
  logic [47:0] now_ms;
  int unsigned tick_max;
  logic [31:0] code_base;
  int unsigned pool_size;

  dedup_history history = new();

  shdr_in_if  in_if ();
  shdr_out_if out_if ();

  signal_history_dedup_ring #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #(TIMEOUT);
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      history.check_outcome(out_if.status, out_if.slot, out_if.entry_count);
    end
  end

  always @(posedge clk) begin : result_sink
    int hold_left;
    if (flood_phase && !flood_done && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
      if (hold_left == 0) flood_done = 1'b1;
    end else begin
      out_if.ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  task automatic offer_item(input ring_item_t it);
    in_if.valid           <= 1'b1;
    in_if.cmd             <= it.cmd;
    in_if.signal_code     <= it.signal_code;
    in_if.bit_length      <= it.bit_length;
    in_if.pulse_length    <= it.pulse_length;
    in_if.protocol_params <= it.protocol_params;
    in_if.inverted        <= it.inverted;
    in_if.repeat_count    <= it.repeat_count;
    in_if.time_ms         <= it.time_ms;
    in_if.delta_ms        <= it.delta_ms;
    do @(posedge clk); while (!in_if.ready);
    history.note_item(it);
    if (!steady && $urandom_range(99) < 18) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (history.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    history.window_ms = w;
  endtask

  function automatic ring_item_t noise_item();
    ring_item_t it;
    it.cmd             = shdr_pkg::CMD_UPSERT;
    it.signal_code     = $urandom();
    it.bit_length      = 8'($urandom());
    it.pulse_length    = 16'($urandom());
    it.protocol_params = $urandom();
    it.inverted        = 1'($urandom());
    it.repeat_count    = 16'($urandom());
    it.time_ms         = {16'($urandom()), 32'($urandom())};
    it.delta_ms        = {16'($urandom()), 32'($urandom())};
    return it;
  endfunction

  function automatic ring_item_t upsert_item(logic [31:0] code, logic [47:0] stamp);
    ring_item_t it;
    it = noise_item();
    it.signal_code = code;
    it.time_ms = stamp;
    return it;
  endfunction

  function automatic ring_item_t shift_item(logic [47:0] delta);
    ring_item_t it;
    it = noise_item();
    it.cmd = shdr_pkg::CMD_SHIFT;
    it.delta_ms = delta;
    return it;
  endfunction

  function automatic ring_item_t random_item();
    ring_item_t  it;
    int unsigned r;
    it = noise_item();
    if ($urandom_range(9) == 0) begin
      it.cmd = shdr_pkg::CMD_SHIFT;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: it.delta_ms = 48'($urandom_range(4000)) - 48'd2000;
        5, 6:          it.delta_ms = {16'($urandom()), 32'($urandom())};
        7:             it.delta_ms = 48'h7FFF_FFFF_FFFF;
        8:             it.delta_ms = 48'h8000_0000_0000;
        default:       it.delta_ms = -48'($urandom_range(1 << 20));
      endcase
    end else begin
      if ($urandom_range(3) != 0) it.signal_code = code_base + $urandom_range(pool_size - 1);
      r = $urandom_range(99);
      if (r < 3) begin
        now_ms = {16'($urandom()), 32'($urandom())};
        it.time_ms = now_ms;
      end else if (r < 5) begin
        now_ms = shdr_pkg::TIME_MAX - 48'($urandom_range(50));
        it.time_ms = now_ms;
      end else if (r < 12) begin
        it.time_ms = now_ms - 48'($urandom_range(tick_max));
      end else begin
        now_ms = now_ms + 48'($urandom_range(tick_max));
        it.time_ms = now_ms;
      end
    end
    return it;
  endfunction

  initial begin
    ring_item_t  it;
    logic [31:0] w;
    in_if.valid           = 1'b0;
    in_if.cmd             = shdr_pkg::CMD_UPSERT;
    in_if.signal_code     = '0;
    in_if.bit_length      = '0;
    in_if.pulse_length    = '0;
    in_if.protocol_params = '0;
    in_if.inverted        = 1'b0;
    in_if.repeat_count    = '0;
    in_if.time_ms         = '0;
    in_if.delta_ms        = '0;
    out_if.ready          = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    rst_n                 = 1'b0;
    steady                = 1'b0;
    flood_phase           = 1'b0;
    flood_done            = 1'b0;
    now_ms                = '0;
    tick_max              = 1;
    code_base             = '0;
    pool_size             = 24;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Window is zero after reset: equal time is a duplicate, one later is not.
    offer_item(shift_item(48'd5));
    it = upsert_item(32'd0, 48'd0);
    it.bit_length = '0;
    it.pulse_length = '0;
    it.protocol_params = '0;
    it.inverted = 1'b0;
    it.repeat_count = '0;
    offer_item(it);
    offer_item(upsert_item(32'd0, 48'd0));
    offer_item(upsert_item(32'd0, 48'd1));
    offer_item(upsert_item(32'd0, 48'd0));
    it = upsert_item(32'hFFFF_FFFF, shdr_pkg::TIME_MAX);
    it.bit_length = '1;
    it.pulse_length = '1;
    it.protocol_params = '1;
    it.inverted = 1'b1;
    it.repeat_count = '1;
    offer_item(it);
    offer_item(shift_item(48'h7FFF_FFFF_FFFF));
    offer_item(shift_item(48'h8000_0000_0000));
    offer_item(shift_item('1));
    offer_item(shift_item('0));
    settle();

    // Fill the ring, then wrap over the oldest entry.
    set_window(32'hFFFF_FFFF);
    for (int i = 1; i <= 15; i++) offer_item(upsert_item(32'(i), 48'(1000 + 10 * i)));

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin w = 32'd20; tick_max = 12; end
        1: begin w = 32'd1000; tick_max = 700; end
        2: begin w = 32'd0; tick_max = 1; end
        3: begin w = 32'hFFFF_FFFF; tick_max = 5000; end
        4: begin w = $urandom(); tick_max = $urandom_range(1 << 20, 1); end
        5: begin w = 32'd7; tick_max = 6; end
        6: begin w = $urandom_range(100000, 1); tick_max = 60000; end
        default: begin w = 32'd300; tick_max = 200; end
      endcase
      set_window(w);
      code_base = $urandom();
      pool_size = (ph == 3) ? 12 : 24;
      steady = (ph == 3);
      flood_phase = (ph == 5);
      for (int n = 0; n < 240; n++) offer_item(random_item());
    end
    steady = 1'b0;
    settle();

    if (history.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
